// File: design/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on a clock with synchronous active-low reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/aes128_pkg.sv
// aes-128 package: tables, types and round functions
package aes128_pkg;

  localparam int unsigned BLOCK_W = 128;
  localparam int unsigned NUM_ROUNDS = 10;
  localparam int unsigned NUM_KEY_WORDS = 44;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned TDATA_W = 136;

  localparam logic CMD_ENCRYPT = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW = 1'b1;

  typedef logic [BLOCK_W-1:0] block_t;
  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic   valid;
    logic   dec;
    block_t st;
  } stage_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

  localparam logic [7:0] RCON [10] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36};

  // byte k of the state sits at bits 127-8k
  function automatic byte_t get_b(block_t s, int k);
    return s[BLOCK_W-1-8*k -: 8];
  endfunction

  function automatic byte_t xt(byte_t b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic block_t sub_bytes(block_t s, logic inv);
    block_t r;
    for (int k = 0; k < 16; k++) begin
      r[BLOCK_W-1-8*k -: 8] = inv ? INV_SBOX[get_b(s, k)] : SBOX[get_b(s, k)];
    end
    return r;
  endfunction

  function automatic block_t shift_rows(block_t s, logic inv);
    block_t r;
    for (int c = 0; c < 4; c++) begin
      for (int w = 0; w < 4; w++) begin
        if (inv) begin
          r[BLOCK_W-1-8*(((c+w)%4)*4+w) -: 8] = get_b(s, c*4+w);
        end else begin
          r[BLOCK_W-1-8*(c*4+w) -: 8] = get_b(s, ((c+w)%4)*4+w);
        end
      end
    end
    return r;
  endfunction

  function automatic block_t mix_columns(block_t s, logic inv);
    block_t r;
    byte_t a0, a1, a2, a3, x2, x4, x8, m9, mb, md, me;
    byte_t x [4];
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) x[j] = get_b(s, c*4+j);
      for (int w = 0; w < 4; w++) begin
        a0 = x[w]; a1 = x[(w+1)%4]; a2 = x[(w+2)%4]; a3 = x[(w+3)%4];
        if (inv) begin
          x2 = xt(a0); x4 = xt(x2); x8 = xt(x4); me = x8 ^ x4 ^ x2;
          x2 = xt(a1); x4 = xt(x2); x8 = xt(x4); mb = x8 ^ x2 ^ a1;
          x2 = xt(a2); x4 = xt(x2); x8 = xt(x4); md = x8 ^ x4 ^ a2;
          x2 = xt(a3); x4 = xt(x2); x8 = xt(x4); m9 = x8 ^ a3;
          r[BLOCK_W-1-8*(c*4+w) -: 8] = me ^ mb ^ md ^ m9;
        end else begin
          r[BLOCK_W-1-8*(c*4+w) -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
        end
      end
    end
    return r;
  endfunction

endpackage

// File: design/aes128_key_sched.sv
// key schedule: expands the configured key into 44 round-key words, one round per cycle
module aes128_key_sched #(
  parameter int unsigned NUM_WORDS = aes128_pkg::NUM_KEY_WORDS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [aes128_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [aes128_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output logic [NUM_WORDS*32-1:0]            round_keys,
  output logic                               busy
);

  localparam int unsigned NR = aes128_pkg::NUM_ROUNDS;

  logic [63:0] key_hi_r, key_lo_r;
  logic [63:0] key_hi_nxt, key_lo_nxt;
  logic [127:0] prev_r;
  logic [7:0] rc_r;
  logic [3:0] rnd_r;
  logic busy_r;
  logic [NUM_WORDS*32-1:0] rk_r;
  logic [31:0] w4, w5, w6, w7;
  logic [127:0] next_key;

  always_comb begin
    key_hi_nxt = key_hi_r;
    key_lo_nxt = key_lo_r;
    if (cfg_we) begin
      if (cfg_index == aes128_pkg::REG_KEY_HIGH) key_hi_nxt = cfg_wdata;
      else key_lo_nxt = cfg_wdata;
    end
  end

  // one round of expansion from the previous four words
  always_comb begin
    w4 = prev_r[127:96] ^ aes128_pkg::sub_word({prev_r[23:0], prev_r[31:24]}) ^ {rc_r, 24'h0};
    w5 = prev_r[95:64] ^ w4;
    w6 = prev_r[63:32] ^ w5;
    w7 = prev_r[31:0] ^ w6;
    next_key = {w4, w5, w6, w7};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hi_r <= '0;
      key_lo_r <= '0;
      prev_r <= '0;
      rk_r[NUM_WORDS*32-1 -: 128] <= '0;
      rc_r <= 8'h01;
      rnd_r <= 4'd1;
      busy_r <= 1'b1;
    end else if (cfg_we) begin
      key_hi_r <= key_hi_nxt;
      key_lo_r <= key_lo_nxt;
      prev_r <= {key_hi_nxt, key_lo_nxt};
      rk_r[NUM_WORDS*32-1 -: 128] <= {key_hi_nxt, key_lo_nxt};
      rc_r <= 8'h01;
      rnd_r <= 4'd1;
      busy_r <= 1'b1;
    end else if (busy_r) begin
      prev_r <= next_key;
      rc_r <= aes128_pkg::xt(rc_r);
      rnd_r <= rnd_r + 4'd1;
      busy_r <= (rnd_r != 4'(NR));
      for (int r = 1; r <= NR; r++) begin
        if (rnd_r == 4'(r)) rk_r[(NUM_WORDS-4-4*r)*32 +: 128] <= next_key;
      end
    end
  end

  assign round_keys = rk_r;
  assign busy = busy_r;

endmodule

// File: design/aes128_round.sv
// one registered cipher round, forward or inverse
module aes128_round #(
  parameter int unsigned ROUND = 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  aes128_pkg::stage_t         in_s,
  input  aes128_pkg::block_t         key_enc,
  input  aes128_pkg::block_t         key_dec,
  output aes128_pkg::stage_t         out_s
);

  aes128_pkg::stage_t st_nxt;
  aes128_pkg::block_t t;
  logic valid_r;
  logic dec_r;
  aes128_pkg::block_t blk_r;
  localparam bit LAST = (ROUND == aes128_pkg::NUM_ROUNDS);

  always_comb begin
    st_nxt = in_s;
    if (in_s.dec) begin
      t = aes128_pkg::sub_bytes(aes128_pkg::shift_rows(in_s.st, 1'b1), 1'b1) ^ key_dec;
      if (!LAST) t = aes128_pkg::mix_columns(t, 1'b1);
    end else begin
      t = aes128_pkg::shift_rows(aes128_pkg::sub_bytes(in_s.st, 1'b0), 1'b0);
      if (!LAST) t = aes128_pkg::mix_columns(t, 1'b0);
      t = t ^ key_enc;
    end
    st_nxt.st = t;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= st_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dec_r <= st_nxt.dec;
      blk_r <= st_nxt.st;
    end
  end

  assign out_s = {valid_r, dec_r, blk_r};

endmodule

// File: design/aes128_block_cipher_unit.sv
// aes-128 top level: key schedule, initial key add and ten round stages
//
//  channel | signals                          | transfer when
//  in      | in_tvalid in_tready in_tdata     | in_tvalid && in_tready
//  out     | out_tvalid out_tready out_tdata  | out_tvalid && out_tready
//  cfg     | cfg_we cfg_index cfg_wdata       | cfg_we
//
// one block per cycle when not stalled; key add stage plus ten round stages
// the whole pipe advances when the output register is empty or taken
// synchronous active-low reset clears all valid bits and expands the all-zero key
// after reset or a key write, in_tready stays low while the schedule
// is expanded one round per cycle
module aes128_block_cipher_unit #(
  parameter int unsigned NUM_WORDS = aes128_pkg::NUM_KEY_WORDS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [0] command, [64:1] block_high, [128:65] block_low, zero fill
  input  logic [aes128_pkg::TDATA_W-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [63:0] result_high, [127:64] result_low
  output logic [aes128_pkg::BLOCK_W-1:0]     out_tdata,
  input  logic                               cfg_we,
  input  logic [aes128_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [aes128_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int unsigned NR = aes128_pkg::NUM_ROUNDS;

  logic [NUM_WORDS*32-1:0] rk;
  logic ks_busy;
  logic en;
  aes128_pkg::stage_t s [NR+1];
  aes128_pkg::stage_t s0_nxt;
  aes128_pkg::block_t in_blk;
  logic s0_valid_r;
  logic s0_dec_r;
  aes128_pkg::block_t s0_blk_r;

  aes128_key_sched #(.NUM_WORDS(NUM_WORDS)) u_ks (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata, .round_keys(rk), .busy(ks_busy)
  );

  function automatic aes128_pkg::block_t rkey(logic [NUM_WORDS*32-1:0] k, int r);
    return k[(NUM_WORDS-4-4*r)*32 +: 128];
  endfunction

  assign en = !s[NR].valid || out_tready;
  assign in_tready = en && !ks_busy;
  assign in_blk = {in_tdata[64:1], in_tdata[128:65]};

  always_comb begin
    s0_nxt.valid = in_tvalid && !ks_busy;
    s0_nxt.dec = in_tdata[0];
    s0_nxt.st = in_blk ^ (in_tdata[0] ? rkey(rk, NR) : rkey(rk, 0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s0_valid_r <= 1'b0;
    else if (en) s0_valid_r <= s0_nxt.valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s0_dec_r <= s0_nxt.dec;
      s0_blk_r <= s0_nxt.st;
    end
  end
  assign s[0] = {s0_valid_r, s0_dec_r, s0_blk_r};

  for (genvar g = 1; g <= NR; g++) begin : g_rnd
    aes128_round #(.ROUND(g)) u_rnd (
      .clk, .rst_n, .en, .in_s(s[g-1]),
      .key_enc(rkey(rk, g)), .key_dec(rkey(rk, NR-g)), .out_s(s[g])
    );
  end

  assign out_tvalid = s[NR].valid;
  assign out_tdata = {s[NR].st[63:0], s[NR].st[127:64]};

endmodule

// File: design/aes128_checker.sv
// port-level checker for the aes-128 unit, bound to the top level
`include "assert_macros.svh"

module aes128_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [127:0] out_tdata,
  input logic       cfg_we
);

  `ASSERT_CLK(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result changed")
  `ASSERT_CLK(a_key_busy, clk, rst_n, cfg_we |=> !in_tready, "input taken during key expansion")
  `ASSERT_CLK(a_stall_ready, clk, rst_n, out_tvalid && !out_tready |-> !in_tready, "input taken during stall")
  `ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_tvalid, "result after reset")

endmodule

bind aes128_block_cipher_unit aes128_checker u_chk (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .out_tdata, .cfg_we
);
